/* hw/rtl/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command codes and constants for the line sequencer.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W       = 5;

    localparam logic [7:0]         MSB_MASK   = 8'h80;
    localparam logic [PHASE_W-1:0] SEND_LAST  = PHASE_W'(3 * BITS_PER_BYTE - 1);
    localparam logic [PHASE_W-1:0] RECV_LAST  = PHASE_W'(2 * BITS_PER_BYTE);

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_SEND_BYTE = 3'd2,
        OP_RECV_BYTE = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_RECV_ACK  = 3'd5,
        OP_IDLE      = 3'd7
    } op_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       cmd_ignored;
    } result_t;

    function automatic logic [7:0] bit_mask(input logic [2:0] idx);
        return MSB_MASK >> idx;
    endfunction

endpackage

/* hw/rtl/i2c_master_bit_engine_top.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine, top level
// Result: the result beat of an accepted tick beat is registered and valid in the
// cycle after. Throughput: one tick beat per cycle unless a full result register
// stalls the input; the result register frees its slot in the same cycle it is drained.
// Reset: idle, SCL and SDA released high, received ack 1, received byte 0.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_top
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  tick_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    step;
    result_t res;

    assign step = in_valid && in_ready;

    i2cm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .tick  (in_data),
        .res   (res)
    );

    i2cm_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid),
        .load_ready (in_ready),
        .load_data  (res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted tick did not produce a result beat");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.done_res || out_data.busy_res))
        else $error("done without busy");

    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.cmd_ignored || out_data.busy_res))
        else $error("command dropped while idle");

endmodule

/* hw/rtl/i2cm_seq.sv */
// ---------------------------------------------------------------------------
// I2C master sequencer core
// Holds the command and line state and computes one bus phase per beat.
// ---------------------------------------------------------------------------
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  tick_t   tick,
    output result_t res
);

    op_t                op_reg, op_next, cur_op;
    logic [PHASE_W-1:0] phase_reg, phase_next, cur_phase;
    logic [7:0]         shift_reg, shift_next, cur_shift;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [7:0]         rxb_reg, rxb_next;
    logic               ack_reg, ack_next;
    logic               cmd_ok;
    logic               last;

    // send byte: bit index and sub-phase of p (p / 3 via multiply by 11, shift 5)
    logic [8:0]         p_x11;
    logic [3:0]         sb_bit;
    logic [PHASE_W-1:0] sb_sub;
    // receive byte: q = p - 1
    logic [PHASE_W-1:0] rq;

    assign p_x11  = 9'(cur_phase) * 9'd11;
    assign sb_bit = p_x11[8:5];
    assign sb_sub = cur_phase - PHASE_W'({1'b0, sb_bit} * 5'd3);
    assign rq     = cur_phase - PHASE_W'(1);

    always_comb
    begin
        cmd_ok = tick.cmd_valid && (tick.command <= 3'(OP_RECV_ACK));
        if (op_reg == OP_IDLE && cmd_ok)
        begin
            cur_op    = op_t'(tick.command);
            cur_phase = '0;
            cur_shift = (tick.command == 3'(OP_SEND_BYTE)) ? tick.tx_byte : shift_reg;
        end
        else
        begin
            cur_op    = op_reg;
            cur_phase = phase_reg;
            cur_shift = shift_reg;
        end
    end

    // next state
    always_comb
    begin
        unique case (cur_op)
            OP_START:     last = cur_phase >= PHASE_W'(3);
            OP_STOP:      last = cur_phase >= PHASE_W'(2);
            OP_SEND_BYTE: last = cur_phase >= SEND_LAST;
            OP_RECV_BYTE: last = cur_phase >= RECV_LAST;
            OP_SEND_ACK:  last = cur_phase >= PHASE_W'(2);
            OP_RECV_ACK:  last = cur_phase >= PHASE_W'(2);
            default:      last = 1'b0;
        endcase

        if (cur_op == OP_IDLE)
        begin
            op_next    = OP_IDLE;
            phase_next = phase_reg;
        end
        else if (last)
        begin
            op_next    = OP_IDLE;
            phase_next = '0;
        end
        else
        begin
            op_next    = cur_op;
            phase_next = cur_phase + PHASE_W'(1);
        end
    end

    // line levels and data
    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = cur_shift;
        rxb_next   = rxb_reg;
        ack_next   = ack_reg;
        unique case (cur_op)
            OP_START:
            begin
                if (cur_phase == PHASE_W'(0))      sda_next = 1'b1;
                else if (cur_phase == PHASE_W'(1)) scl_next = 1'b1;
                else if (cur_phase == PHASE_W'(2)) sda_next = 1'b0;
                else                               scl_next = 1'b0;
            end
            OP_STOP:
            begin
                if (cur_phase == PHASE_W'(0))      sda_next = 1'b0;
                else if (cur_phase == PHASE_W'(1)) scl_next = 1'b1;
                else                               sda_next = 1'b1;
            end
            OP_SEND_BYTE:
            begin
                if (sb_sub == PHASE_W'(0))
                    sda_next = |(cur_shift & bit_mask(sb_bit[2:0]));
                else if (sb_sub == PHASE_W'(1))
                    scl_next = 1'b1;
                else
                    scl_next = 1'b0;
            end
            OP_RECV_BYTE:
            begin
                if (cur_phase == PHASE_W'(0))
                begin
                    sda_next   = 1'b1;
                    shift_next = '0;
                end
                else
                begin
                    if (!rq[0])
                        scl_next = 1'b1;
                    else
                    begin
                        if (tick.sda_in)
                            shift_next = cur_shift | bit_mask(rq[3:1]);
                        scl_next = 1'b0;
                    end
                    if (last)
                        rxb_next = shift_next;
                end
            end
            OP_SEND_ACK:
            begin
                if (cur_phase == PHASE_W'(0))      sda_next = tick.ack_out;
                else if (cur_phase == PHASE_W'(1)) scl_next = 1'b1;
                else                               scl_next = 1'b0;
            end
            OP_RECV_ACK:
            begin
                if (cur_phase == PHASE_W'(0))      sda_next = 1'b1;
                else if (cur_phase == PHASE_W'(1)) scl_next = 1'b1;
                else
                begin
                    ack_next = tick.sda_in;
                    scl_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        res.scl         = scl_next;
        res.sda_drive   = sda_next;
        res.busy_res    = (cur_op != OP_IDLE);
        res.done_res    = last;
        res.rx_byte     = rxb_next;
        res.ack_in      = ack_next;
        res.cmd_ignored = (op_reg != OP_IDLE) && tick.cmd_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            phase_reg <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rxb_reg   <= '0;
            ack_reg   <= 1'b1;
        end
        else if (step)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rxb_reg   <= rxb_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

/* hw/rtl/i2cm_out_reg.sv */
// ---------------------------------------------------------------------------
// I2C master result register
// Holds one result beat and decouples the output handshake from the input.
// ---------------------------------------------------------------------------
module i2cm_out_reg
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load_valid,
    output logic    load_ready,
    input  result_t load_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            data_reg <= load_data;
    end

endmodule
